@@ hdl/i2cs_pkg.sv @@
// Types and constants shared by the two-wire slave register file.
package i2cs_pkg;

  // Register file geometry, fixed by the width of the reported register index
  localparam int NUM_REGS  = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [6:0] DEV_ADDR_RESET = 7'h10;
  localparam logic [7:0] REG1_RESET     = 8'h83;

  // Scaled reciprocal of NUM_REGS, rounded up; exact quotients for seven-bit
  // map values while NUM_REGS stays at or below eight
  localparam int MAP_RECIP_SHIFT = 10;
  localparam int MAP_RECIP       = ((1 << MAP_RECIP_SHIFT) + NUM_REGS - 1) / NUM_REGS;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SELECT   = 3'd1,
    PH_MAP      = 3'd2,
    PH_WRITE    = 3'd3,
    PH_READ_ACK = 3'd4,
    PH_READ     = 3'd5
  } phase_t;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Reduce a seven-bit map value modulo NUM_REGS: quotient by reciprocal
  // multiplication, then subtract the multiple back out
  function automatic reg_idx_t map_reduce(input logic [6:0] value);
    logic [17:0] prod;
    logic [6:0]  quot;
    logic [6:0]  rem;
    prod = {11'd0, value} * 18'(MAP_RECIP);
    quot = prod[MAP_RECIP_SHIFT +: 7];
    rem  = value - 7'(quot * NUM_REGS);
    return rem[REG_IDX_W-1:0];
  endfunction

  // Step the register index, wrapping at NUM_REGS
  function automatic reg_idx_t idx_advance(input reg_idx_t idx);
    if (idx == REG_IDX_W'(NUM_REGS - 1)) begin
      return '0;
    end
    return idx + REG_IDX_W'(1);
  endfunction

endpackage

@@ hdl/i2c_slave_register_file.sv @@
// Two-wire bus slave with a small register file, driven by line-change events.
//
// Usage:
//   Each input transfer (opcode, line_level) reports a new level on the data
//   line (opcode 0) or the clock line (opcode 1). Start and stop conditions
//   are seen as data changes while the clock is high. The slave matches the
//   address byte against device_address, takes a map byte on writes, then
//   writes data bytes or shifts register bytes out MSB first on reads.
//   Every input transfer produces exactly one output transfer carrying the
//   data level the slave drives (1 = released) and a register-write strobe
//   with its index and value.
//   Timing: the state update is a single registered pass, so a result appears
//   in the cycle after its input transfer, and one input is taken every cycle unless a result is held.
//   The output register is the only buffering: while a result is held by
//   out_stall, in_stall is raised and the next item waits at the input.
//   Configuration: cfg_write loads cfg_data into the device address; write it
//   only while no transfer is outstanding.
//   Reset (rst, synchronous): the bus state returns to idle with the data
//   line released, the address becomes 0x10, register 1 becomes 0x83 and the
//   other registers clear. No output transfer is pending after reset.
module i2c_slave_register_file
  import i2cs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  // line-change events
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic       line_level,
  // results
  output logic       out_valid,
  input  logic       out_stall,
  output logic       sda_out,
  output logic       reg_write,
  output logic [2:0] reg_index,
  output logic [7:0] reg_value
);

  // Bus state
  logic [6:0] device_address;
  logic       clock_level,    clock_level_next;
  logic       data_in_level,  data_in_level_next;
  logic       data_out_level, data_out_level_next;
  phase_t     phase,          phase_next;
  logic [3:0] bit_count,      bit_count_next;
  logic [7:0] shifter,        shifter_next;
  logic       ptr_auto,       ptr_auto_next;   // map byte bit 7: auto-increment
  reg_idx_t   ptr_index,      ptr_index_next;  // always kept below NUM_REGS
  logic [7:0] regs [NUM_REGS];

  logic       wr_next;
  reg_idx_t   wr_idx_next;
  logic [7:0] wr_val_next;
  logic [7:0] rd_byte;
  logic       in_take;

  // Hold the input whenever a finished result is still waiting
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign rd_byte = regs[ptr_index];

  always_comb begin
    clock_level_next    = clock_level;
    data_in_level_next  = data_in_level;
    data_out_level_next = data_out_level;
    phase_next          = phase;
    bit_count_next      = bit_count;
    shifter_next        = shifter;
    ptr_auto_next       = ptr_auto;
    ptr_index_next      = ptr_index;
    wr_next             = 1'b0;
    wr_idx_next         = '0;
    wr_val_next         = '0;

    if (!opcode) begin
      // Data line: start or stop only while the clock is high
      if (line_level != data_in_level) begin
        data_in_level_next = line_level;
        if (clock_level) begin
          if (line_level) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next     = PH_SELECT;
            bit_count_next = '0;
          end
          data_out_level_next = 1'b1;
        end
      end
    end else if (line_level != clock_level) begin
      clock_level_next = line_level;
      unique case (phase)
        PH_SELECT, PH_MAP, PH_WRITE: begin
          if (bit_count < 4'd8) begin
            if (line_level) begin
              shifter_next   = {shifter[6:0], data_in_level};
              bit_count_next = bit_count + 4'd1;
            end
          end else if (line_level) begin
            bit_count_next = bit_count + 4'd1;
          end else if (bit_count == 4'd8) begin
            // Byte complete on the falling clock: act on it and drive the ack unless the address does not match
            unique case (phase)
              PH_SELECT: begin
                if (shifter[7:1] != device_address) begin
                  phase_next = PH_IDLE;
                end else if (!shifter[0]) begin
                  phase_next          = PH_MAP;
                  data_out_level_next = 1'b0;
                end else begin
                  phase_next          = PH_READ_ACK;
                  data_out_level_next = 1'b0;
                end
              end
              PH_MAP: begin
                ptr_auto_next       = shifter[7];
                ptr_index_next      = map_reduce(shifter[6:0]);
                phase_next          = PH_WRITE;
                data_out_level_next = 1'b0;
              end
              default: begin
                wr_next             = 1'b1;
                wr_idx_next         = ptr_index;
                wr_val_next         = shifter;
                data_out_level_next = 1'b0;
                if (ptr_auto) begin
                  ptr_index_next = idx_advance(ptr_index);
                end
              end
            endcase
          end else begin
            // End of the ack slot: release the line
            bit_count_next      = '0;
            data_out_level_next = 1'b1;
          end
        end
        PH_READ_ACK: begin
          bit_count_next = '0;
          phase_next     = PH_READ;
        end
        PH_READ: begin
          if (bit_count < 4'd8) begin
            if (line_level) begin
              bit_count_next = bit_count + 4'd1;
            end else if (bit_count == '0) begin
              // First bit of a byte: fetch the register
              data_out_level_next = rd_byte[7];
              shifter_next        = {rd_byte[6:0], 1'b0};
              if (ptr_auto) begin
                ptr_index_next = idx_advance(ptr_index);
              end
            end else begin
              data_out_level_next = shifter[7];
              shifter_next        = {shifter[6:0], 1'b0};
            end
          end else if (line_level) begin
            // Master's ack sampled: a high level ends the read
            if (data_in_level) begin
              phase_next = PH_IDLE;
            end
            bit_count_next = '0;
          end else begin
            data_out_level_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
      clock_level    <= 1'b0;
      data_in_level  <= 1'b0;
      data_out_level <= 1'b1;
      phase          <= PH_IDLE;
      bit_count      <= '0;
      shifter        <= '0;
      ptr_auto       <= 1'b0;
      ptr_index      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        device_address <= cfg_data;
      end
      if (in_take) begin
        clock_level    <= clock_level_next;
        data_in_level  <= data_in_level_next;
        data_out_level <= data_out_level_next;
        phase          <= phase_next;
        bit_count      <= bit_count_next;
        shifter        <= shifter_next;
        ptr_auto       <= ptr_auto_next;
        ptr_index      <= ptr_index_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= (i == 1) ? REG1_RESET : 8'h00;
      end
    end else if (in_take && wr_next) begin
      regs[wr_idx_next] <= wr_val_next;
    end
  end

  // Result register: payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      sda_out   <= data_out_level_next;
      reg_write <= wr_next;
      reg_index <= wr_idx_next;
      reg_value <= wr_val_next;
    end
  end

`ifndef SYNTHESIS
  // The stored pointer never leaves the register file
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr_index < REG_IDX_W'(NUM_REGS))
    else $error("map pointer out of range");

  // A register write on an accepted item is reported in the next result
  a_write_reported: assert property (@(posedge clk) disable iff (rst)
    (in_take && wr_next) |=> (out_valid && reg_write))
    else $error("register write not reported");

  // A reported write names a register that exists
  a_write_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reg_write) |-> (reg_index < REG_IDX_W'(NUM_REGS)))
    else $error("reported register index out of range");
`endif

endmodule

@@ dv/tb_i2c_slave_register_file.sv @@
// Self-checking testbench for the two-wire slave register file: bus sequences in, line drive out.
`timescale 1ns / 1ps

import i2cs_pkg::*;

// One result transfer: slave data drive plus register-write strobe
typedef struct packed {
  logic       sda;
  logic       wr;
  logic [2:0] idx;
  logic [7:0] val;
} bus_result_t;

class i2c_reg_scoreboard;
  logic [6:0]  dev_addr;
  logic        scl_q;
  logic        sda_q;
  logic        drive_q;
  phase_t      ph;
  logic [3:0]  nbits;
  logic [7:0]  shreg;
  logic [7:0]  sel;
  logic [7:0]  mptr;
  logic [7:0]  regs [NUM_REGS];
  bus_result_t due_results[$];
  int unsigned fails;

  function new();
    dev_addr = DEV_ADDR_RESET;
    scl_q    = 1'b0;
    sda_q    = 1'b0;
    drive_q  = 1'b1;
    ph       = PH_IDLE;
    nbits    = '0;
    shreg    = '0;
    sel      = '0;
    mptr     = '0;
    foreach (regs[i]) regs[i] = '0;
    regs[1]  = REG1_RESET;
    fails    = 0;
  endfunction

  function logic [2:0] map_idx();
    return 3'(int'(mptr[6:0]) % NUM_REGS);
  endfunction

  function void bump_ptr();
    if (mptr[7]) mptr = {1'b1, 7'((int'(map_idx()) + 1) % NUM_REGS)};
  endfunction

  // Act on the ninth falling clock of a received byte
  function void finish_byte(inout bus_result_t r);
    logic [2:0] i;
    case (ph)
      PH_SELECT: begin
        sel = shreg;
        if (sel[7:1] != dev_addr) ph = PH_IDLE;
        else if (!sel[0]) ph = PH_MAP;
        else ph = PH_READ_ACK;
      end
      PH_MAP: begin
        mptr = {shreg[7], 7'(int'(shreg[6:0]) % NUM_REGS)};
        ph   = PH_WRITE;
      end
      default: begin
        i       = map_idx();
        regs[i] = shreg;
        r.wr    = 1'b1;
        r.idx   = i;
        r.val   = shreg;
        bump_ptr();
      end
    endcase
    if (ph != PH_IDLE) drive_q = 1'b0;
  endfunction

  // Advance the bus state for one accepted line change and queue its result
  function void apply_line_change(logic op, logic lvl);
    bus_result_t r;
    r = '0;
    if (!op) begin
      if (lvl != sda_q) begin
        sda_q = lvl;
        if (scl_q) begin
          if (lvl) ph = PH_IDLE;
          else begin
            ph    = PH_SELECT;
            nbits = '0;
          end
          drive_q = 1'b1;
        end
      end
    end else if (lvl != scl_q) begin
      scl_q = lvl;
      case (ph)
        PH_SELECT, PH_MAP, PH_WRITE: begin
          if (nbits < 8) begin
            if (lvl) begin
              shreg = {shreg[6:0], sda_q};
              nbits = nbits + 4'd1;
            end
          end else if (lvl) nbits = nbits + 4'd1;
          else if (nbits == 8) finish_byte(r);
          else begin
            nbits   = '0;
            drive_q = 1'b1;
          end
        end
        PH_READ_ACK: begin
          nbits = '0;
          ph    = PH_READ;
        end
        PH_READ: begin
          if (nbits < 8) begin
            if (lvl) nbits = nbits + 4'd1;
            else begin
              if (nbits == 0) begin
                shreg = regs[map_idx()];
                bump_ptr();
              end
              drive_q = shreg[7];
              shreg   = shreg << 1;
            end
          end else if (lvl) begin
            if (sda_q) ph = PH_IDLE;
            nbits = '0;
          end else drive_q = 1'b1;
        end
        default: ;
      endcase
    end
    r.sda = drive_q;
    due_results.push_back(r);
  endfunction

  task report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    fails++;
  endtask

  task match_result(bus_result_t got);
    bus_result_t want;
    if (due_results.size() == 0) begin
      report("result transfer with nothing outstanding");
    end else begin
      want = due_results.pop_front();
      if (got.sda != want.sda)
        report($sformatf("sda_out %0d, predicted %0d", got.sda, want.sda));
      if (got.wr != want.wr)
        report($sformatf("reg_write %0d, predicted %0d", got.wr, want.wr));
      if (got.idx != want.idx)
        report($sformatf("reg_index %0d, predicted %0d", got.idx, want.idx));
      if (got.val != want.val)
        report($sformatf("reg_value 0x%02h, predicted 0x%02h", got.val, want.val));
    end
  endtask
endclass

module tb_i2c_slave_register_file;

  // Cycles with no transfer on either side before the run is declared hung
  localparam int unsigned HANG_LIMIT = 2000;
  // Items per address setting; five settings give roughly 1100 items
  localparam int unsigned ITEMS_PER_SETTING = 220;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [6:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic       opcode;
  logic       line_level;
  logic       out_valid;
  logic       out_stall;
  logic       sda_out;
  logic       reg_write;
  logic [2:0] reg_index;
  logic [7:0] reg_value;

  i2c_reg_scoreboard sb;

  // Line levels as last sent to the block, so bus sequences stay well formed
  logic        scl_lv;
  logic        sda_lv;
  logic [6:0]  cur_addr;
  bit          quiet;
  int unsigned n_items;
  int unsigned idle_cycles;

  i2c_slave_register_file dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .line_level (line_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sda_out    (sda_out),
    .reg_write  (reg_write),
    .reg_index  (reg_index),
    .reg_value  (reg_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one line change and hold it until the block takes it. Entered and
  // left at a falling edge; valid stays high on exit so back-to-back transfers
  // never lower and raise it in the same step.
  task automatic send(input logic op, input logic lvl);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    line_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_line_change(op, lvl);
    @(negedge clk);
    // Count only real level changes; repeats are ignored by the block
    if (op) begin
      if (lvl != scl_lv) n_items++;
      scl_lv = lvl;
    end else begin
      if (lvl != sda_lv) n_items++;
      sda_lv = lvl;
    end
  endtask

  task automatic set_scl(input logic v);
    if (scl_lv != v) send(1'b1, v);
  endtask

  task automatic set_sda(input logic v);
    if (sda_lv != v) send(1'b0, v);
  endtask

  // Start, or repeated start: raise data with the clock low, then clock, then drop data
  task automatic bus_start();
    if (!sda_lv) begin
      set_scl(1'b0);
      set_sda(1'b1);
    end
    set_scl(1'b1);
    set_sda(1'b0);
  endtask

  task automatic bus_stop();
    set_scl(1'b0);
    set_sda(1'b0);
    set_scl(1'b1);
    set_sda(1'b1);
  endtask

  // One clock period: change data only while the clock is low
  task automatic put_bit(input logic b);
    set_scl(1'b0);
    set_sda(b);
    set_scl(1'b1);
  endtask

  // Eight bits MSB first, then a released acknowledge slot for the slave
  task automatic put_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) put_bit(b[i]);
    put_bit(1'b1);
  endtask

  task automatic write_txn(input logic [6:0] a);
    int n;
    n = $urandom_range(4, 1);
    bus_start();
    put_byte({a, 1'b0});
    put_byte(8'($urandom));
    repeat (n) put_byte(8'($urandom));
  endtask

  // Master releases data for each byte and acknowledges all but the last
  task automatic read_txn(input logic [6:0] a);
    int n;
    n = $urandom_range(5, 1);
    bus_start();
    put_byte({a, 1'b1});
    for (int k = 0; k < n; k++) begin
      repeat (8) put_bit(1'b1);
      put_bit(k == n - 1);
    end
  endtask

  // Address for the next sequence: mostly our own, sometimes any at all
  function automatic logic [6:0] pick_addr();
    return ($urandom_range(99) < 80) ? cur_addr : 7'($urandom);
  endfunction

  task automatic one_sequence();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      write_txn(pick_addr());
      if ($urandom_range(99) < 30) read_txn(pick_addr());
      bus_stop();
    end else if (r < 80) begin
      read_txn(pick_addr());
      // Now and then leave the bus held so the next start is a repeated one
      if ($urandom_range(99) < 85) bus_stop();
    end else if (r < 90) begin
      // Broken sequence: cut off part way through a byte
      bus_start();
      repeat ($urandom_range(20, 0)) put_bit(1'($urandom));
      if ($urandom_range(1)) bus_stop();
    end else begin
      // Raw noise, repeats of the present level included
      repeat ($urandom_range(6, 1)) send(1'($urandom), 1'($urandom));
    end
  endtask

  // Hold the sender until every predicted result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic load_address(input logic [6:0] a);
    settle();
    cfg_write   <= 1'b1;
    cfg_data    <= a;
    sb.dev_addr  = a;
    cur_addr     = a;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Result side: sample at the rising edge, choose the stall at the falling edge
  initial begin : result_side
    bus_result_t got;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.sda = sda_out;
        got.wr  = reg_write;
        got.idx = reg_index;
        got.val = reg_value;
        sb.match_result(got);
      end
      @(negedge clk);
      out_stall <= !quiet && ($urandom_range(99) < 19);
    end
  end

  // Watchdog: count cycles in which neither side moves a transfer
  initial begin : watchdog
    idle_cycles = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("timeout after %0d cycles with no transfer", HANG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [6:0] plan_addr;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    opcode     = 1'b0;
    line_level = 1'b0;
    scl_lv     = 1'b0;
    sda_lv     = 1'b0;
    cur_addr   = DEV_ADDR_RESET;
    quiet      = 1'b0;
    n_items    = 0;
    sb         = new();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Opening checks: repeated levels, data moving under a low clock,
    // a clock edge while idle, then bare start and stop conditions
    send(1'b1, 1'b0);
    send(1'b0, 1'b0);
    send(1'b0, 1'b1);
    send(1'b0, 1'b0);
    send(1'b0, 1'b1);
    send(1'b1, 1'b1);
    send(1'b1, 1'b1);
    send(1'b0, 1'b0);
    send(1'b0, 1'b1);
    send(1'b0, 1'b0);
    send(1'b0, 1'b0);
    send(1'b0, 1'b1);

    // Five address settings: reset value, both extremes, two random ones.
    // The third runs with no idling on either side.
    for (int p = 0; p < 5; p++) begin
      case (p)
        1:       plan_addr = 7'h7f;
        2:       plan_addr = 7'h00;
        default: plan_addr = 7'($urandom);
      endcase
      if (p > 0) load_address(plan_addr);
      quiet = (p == 2);
      while (n_items < (p + 1) * ITEMS_PER_SETTING) one_sequence();
    end
    quiet = 1'b0;

    // Drain: drop valid, wait for every result, then check that none is left
    settle();
    repeat (6) @(posedge clk);
    if (sb.due_results.size() != 0) sb.report("predicted results never arrived");
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/i2cs_pkg.sv
hdl/i2c_slave_register_file.sv
dv/tb_i2c_slave_register_file.sv
